// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the backoff checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/ebj_pkg.sv =====
// ----------------------------------------------------------------------------
// ebj_pkg
// Types, constants and microcode ROM of the exponential backoff block.
// ----------------------------------------------------------------------------
package ebj_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int UPC_W      = 5;
   localparam int ACC_W      = 112;
   localparam int SMAG_LSB   = 16;  // Q8.16 growth product
   localparam int JMAG_LSB   = 47;  // Q1.31 * Q1.16 jitter product

   localparam logic [62:0] MAG_MAX = {63{1'b1}};
   localparam logic [30:0] LCG_MUL = 31'd1103515245;
   localparam logic [30:0] LCG_INC = 31'd12345;

   typedef enum logic [1:0] {
      ACT_BEGIN = 2'd0,
      ACT_STEP  = 2'd1,
      ACT_RESET = 2'd2
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_INITIAL_TIMEOUT = 3'd0,
      REG_GROWTH_FACTOR   = 3'd1,
      REG_JITTER_FRACTION = 3'd2,
      REG_MIN_TIMEOUT     = 3'd3,
      REG_MAX_TIMEOUT     = 3'd4,
      REG_RNG_SEED        = 3'd5
   } csr_reg_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [62:0] now_ms;
   } req_payload_type;

   typedef struct packed {
      logic [62:0] deadline_ms;
   } rsp_payload_type;

   typedef struct packed {
      logic [31:0] initial_timeout;
      logic [23:0] growth_factor;
      logic [16:0] jitter_fraction;
      logic [31:0] min_timeout;
      logic [31:0] max_timeout;
   } cfg_type;

   typedef struct packed {
      logic        load;
      logic [30:0] value;
   } seed_wr_type;

   localparam cfg_type CFG_RESET = '{
      initial_timeout: 32'd1000,
      growth_factor:   24'd104858,
      jitter_fraction: 17'd13107,
      min_timeout:     32'd20000,
      max_timeout:     32'd120000
   };
   localparam logic [30:0] SEED_RESET = 31'd1;

   // control word fields
   typedef enum logic [2:0] {
      MA_ZERO, MA_GROWTH, MA_LCG_MUL, MA_ABSD, MA_COEF_LO, MA_COEF_HI
   } mul_a_type;

   typedef enum logic [2:0] {
      MB_ZERO, MB_TMAG_LO, MB_TMAG_HI, MB_LCG, MB_JF, MB_SMAG_LO, MB_SMAG_HI
   } mul_b_type;

   typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_op_type;
   typedef enum logic [1:0] {SH_0, SH_32, SH_64} acc_sh_type;

   typedef enum logic [3:0] {
      WB_NONE, WB_LOAD_INIT, WB_LCG, WB_SMAG, WB_COEF, WB_JMAG, WB_CLAMP,
      WB_COMBINE, WB_DEADLINE
   } wb_op_type;

   typedef enum logic [2:0] {
      SEQ_NEXT, SEQ_BRANCH, SEQ_JUMP, SEQ_EMIT, SEQ_DONE
   } seq_op_type;

   typedef enum logic {ST_IDLE, ST_RUN} seq_state_type;

   typedef struct packed {
      mul_a_type              a_sel;
      mul_b_type              b_sel;
      acc_op_type             acc_op;
      acc_sh_type             acc_sh;
      wb_op_type              wb;
      seq_op_type             seq;
      action_type             cond_act;
      logic [UPC_W-1:0]       target;
   } ctrl_word_type;

   typedef struct packed {
      ctrl_word_type cw;
      logic          accept;
      logic          emit;
   } dp_ctrl_type;

   // microprogram entry points
   localparam logic [UPC_W-1:0] UA_DISPATCH = 5'd0;
   localparam logic [UPC_W-1:0] UA_BEGIN    = 5'd4;
   localparam logic [UPC_W-1:0] UA_DEADLINE = 5'd5;
   localparam logic [UPC_W-1:0] UA_EMIT     = 5'd6;
   localparam logic [UPC_W-1:0] UA_RESET    = 5'd7;
   localparam logic [UPC_W-1:0] UA_STEP     = 5'd8;

   localparam ctrl_word_type UCODE_NOP = '{
      a_sel: MA_ZERO, b_sel: MB_ZERO, acc_op: ACC_HOLD, acc_sh: SH_0,
      wb: WB_NONE, seq: SEQ_DONE, cond_act: ACT_BEGIN, target: UA_DISPATCH
   };

   function automatic ctrl_word_type cw_make(
      input mul_a_type        a,
      input mul_b_type        b,
      input acc_op_type       acc,
      input acc_sh_type       sh,
      input wb_op_type        wb,
      input seq_op_type       seq,
      input action_type       cond,
      input logic [UPC_W-1:0] target
   );
      ctrl_word_type cw;
      cw.a_sel    = a;
      cw.b_sel    = b;
      cw.acc_op   = acc;
      cw.acc_sh   = sh;
      cw.wb       = wb;
      cw.seq      = seq;
      cw.cond_act = cond;
      cw.target   = target;
      return cw;
   endfunction

   // Step program: growth product over two halves, LCG advance, jitter
   // coefficient, four-part jitter product, clamp, combine, deadline.
   function automatic ctrl_word_type ucode_rom(input logic [UPC_W-1:0] addr);
      ctrl_word_type cw;
      cw = UCODE_NOP;
      unique case (addr)
         UA_DISPATCH:
            cw = cw_make(MA_ZERO, MB_ZERO, ACC_HOLD, SH_0, WB_NONE,
                         SEQ_BRANCH, ACT_STEP, UA_STEP);
         UA_DISPATCH + 5'd1:
            cw = cw_make(MA_ZERO, MB_ZERO, ACC_HOLD, SH_0, WB_NONE,
                         SEQ_BRANCH, ACT_BEGIN, UA_BEGIN);
         UA_DISPATCH + 5'd2:
            cw = cw_make(MA_ZERO, MB_ZERO, ACC_HOLD, SH_0, WB_NONE,
                         SEQ_BRANCH, ACT_RESET, UA_RESET);
         UA_DISPATCH + 5'd3:
            cw = UCODE_NOP;
         UA_BEGIN:
            cw = cw_make(MA_ZERO, MB_ZERO, ACC_HOLD, SH_0, WB_LOAD_INIT,
                         SEQ_NEXT, ACT_BEGIN, UA_DISPATCH);
         UA_DEADLINE:
            cw = cw_make(MA_ZERO, MB_ZERO, ACC_HOLD, SH_0, WB_DEADLINE,
                         SEQ_NEXT, ACT_BEGIN, UA_DISPATCH);
         UA_EMIT:
            cw = cw_make(MA_ZERO, MB_ZERO, ACC_HOLD, SH_0, WB_NONE,
                         SEQ_EMIT, ACT_BEGIN, UA_DISPATCH);
         UA_RESET:
            cw = cw_make(MA_ZERO, MB_ZERO, ACC_HOLD, SH_0, WB_LOAD_INIT,
                         SEQ_DONE, ACT_BEGIN, UA_DISPATCH);
         UA_STEP:
            cw = cw_make(MA_GROWTH, MB_TMAG_LO, ACC_HOLD, SH_0, WB_NONE,
                         SEQ_NEXT, ACT_BEGIN, UA_DISPATCH);
         UA_STEP + 5'd1:
            cw = cw_make(MA_GROWTH, MB_TMAG_HI, ACC_LOAD, SH_0, WB_NONE,
                         SEQ_NEXT, ACT_BEGIN, UA_DISPATCH);
         UA_STEP + 5'd2:
            cw = cw_make(MA_LCG_MUL, MB_LCG, ACC_ADD, SH_32, WB_NONE,
                         SEQ_NEXT, ACT_BEGIN, UA_DISPATCH);
         UA_STEP + 5'd3:
            cw = cw_make(MA_ZERO, MB_ZERO, ACC_HOLD, SH_0, WB_LCG,
                         SEQ_NEXT, ACT_BEGIN, UA_DISPATCH);
         UA_STEP + 5'd4:
            cw = cw_make(MA_ABSD, MB_JF, ACC_HOLD, SH_0, WB_SMAG,
                         SEQ_NEXT, ACT_BEGIN, UA_DISPATCH);
         UA_STEP + 5'd5:
            cw = cw_make(MA_ZERO, MB_ZERO, ACC_HOLD, SH_0, WB_COEF,
                         SEQ_NEXT, ACT_BEGIN, UA_DISPATCH);
         UA_STEP + 5'd6:
            cw = cw_make(MA_COEF_LO, MB_SMAG_LO, ACC_HOLD, SH_0, WB_NONE,
                         SEQ_NEXT, ACT_BEGIN, UA_DISPATCH);
         UA_STEP + 5'd7:
            cw = cw_make(MA_COEF_LO, MB_SMAG_HI, ACC_LOAD, SH_0, WB_NONE,
                         SEQ_NEXT, ACT_BEGIN, UA_DISPATCH);
         UA_STEP + 5'd8:
            cw = cw_make(MA_COEF_HI, MB_SMAG_LO, ACC_ADD, SH_32, WB_NONE,
                         SEQ_NEXT, ACT_BEGIN, UA_DISPATCH);
         UA_STEP + 5'd9:
            cw = cw_make(MA_COEF_HI, MB_SMAG_HI, ACC_ADD, SH_32, WB_NONE,
                         SEQ_NEXT, ACT_BEGIN, UA_DISPATCH);
         UA_STEP + 5'd10:
            cw = cw_make(MA_ZERO, MB_ZERO, ACC_ADD, SH_64, WB_NONE,
                         SEQ_NEXT, ACT_BEGIN, UA_DISPATCH);
         UA_STEP + 5'd11:
            cw = cw_make(MA_ZERO, MB_ZERO, ACC_HOLD, SH_0, WB_JMAG,
                         SEQ_NEXT, ACT_BEGIN, UA_DISPATCH);
         UA_STEP + 5'd12:
            cw = cw_make(MA_ZERO, MB_ZERO, ACC_HOLD, SH_0, WB_CLAMP,
                         SEQ_NEXT, ACT_BEGIN, UA_DISPATCH);
         UA_STEP + 5'd13:
            cw = cw_make(MA_ZERO, MB_ZERO, ACC_HOLD, SH_0, WB_COMBINE,
                         SEQ_JUMP, ACT_BEGIN, UA_DEADLINE);
         default:
            cw = UCODE_NOP;
      endcase
      return cw;
   endfunction

endpackage

// ===== rtl/ebj_chan_if.sv =====
// ----------------------------------------------------------------------------
// ebj_chan_if
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface ebj_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/ebj_csr.sv =====
// ----------------------------------------------------------------------------
// ebj_csr
// Configuration registers; a seed write reloads the generator state.
// ----------------------------------------------------------------------------
module ebj_csr import ebj_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg,
   output seed_wr_type           seed_wr
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in        = cfg_ff;
      seed_wr.load  = 1'b0;
      seed_wr.value = csr_wdata[30:0];
      if (csr_we) begin
         unique case (csr_index)
            REG_INITIAL_TIMEOUT: cfg_in.initial_timeout = csr_wdata[31:0];
            REG_GROWTH_FACTOR:   cfg_in.growth_factor   = csr_wdata[23:0];
            REG_JITTER_FRACTION: cfg_in.jitter_fraction = csr_wdata[16:0];
            REG_MIN_TIMEOUT:     cfg_in.min_timeout     = csr_wdata[31:0];
            REG_MAX_TIMEOUT:     cfg_in.max_timeout     = csr_wdata[31:0];
            REG_RNG_SEED:        seed_wr.load           = 1'b1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/ebj_seq.sv =====
// ----------------------------------------------------------------------------
// ebj_seq
// Microcode sequencer: step counter, control ROM, dispatch on action.
// ----------------------------------------------------------------------------
module ebj_seq import ebj_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [1:0]  action,
   input  logic        out_free,
   output logic        ready,
   output dp_ctrl_type ctrl
);

   seq_state_type    state_ff;
   seq_state_type    state_in;
   logic [UPC_W-1:0] upc_ff;
   logic [UPC_W-1:0] upc_in;
   logic [1:0]       action_ff;
   logic [1:0]       action_in;
   ctrl_word_type    cw;

   assign cw = ucode_rom(upc_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (cw.seq == SEQ_DONE || (cw.seq == SEQ_EMIT && out_free)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ready       = 1'b0;
      ctrl.cw     = UCODE_NOP;
      ctrl.accept = accept;
      ctrl.emit   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            ready = 1'b1;
         end
         ST_RUN: begin
            ctrl.cw   = cw;
            ctrl.emit = (cw.seq == SEQ_EMIT) && out_free;
         end
         default: ready = 1'b0;
      endcase
   end

   // step counter
   always_comb begin
      upc_in    = upc_ff;
      action_in = action_ff;
      if (state_ff == ST_IDLE) begin
         if (accept) begin
            upc_in    = UA_DISPATCH;
            action_in = action;
         end
      end else begin
         unique case (cw.seq)
            SEQ_NEXT:   upc_in = upc_ff + 1'b1;
            SEQ_BRANCH: upc_in = (action_ff == cw.cond_act) ? cw.target : upc_ff + 1'b1;
            SEQ_JUMP:   upc_in = cw.target;
            SEQ_EMIT:   upc_in = upc_ff;
            SEQ_DONE:   upc_in = upc_ff;
            default:    upc_in = upc_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         upc_ff   <= UA_DISPATCH;
      end else begin
         state_ff <= state_in;
         upc_ff   <= upc_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff <= action_in;
   end

endmodule

// ===== rtl/ebj_dp.sv =====
// ----------------------------------------------------------------------------
// ebj_dp
// Datapath: shared 32x32 multiplier, 112-bit accumulator, timeout state,
// generator state and the result register.
// ----------------------------------------------------------------------------
module ebj_dp import ebj_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  dp_ctrl_type ctrl,
   input  cfg_type     cfg,
   input  seed_wr_type seed_wr,
   input  logic [62:0] now_ms,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   output logic [62:0] rsp_deadline_ms,
   output logic        out_free
);

   // timeout held as sign and magnitude; sign is set only for nonzero
   logic [62:0]      tmag_ff, tmag_in;
   logic             tneg_ff, tneg_in;
   logic [30:0]      lcg_ff, lcg_in;
   logic [63:0]      prod_ff, prod_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [62:0]      smag_ff, smag_in;
   logic [48:0]      coef_ff, coef_in;
   logic             cfneg_ff, cfneg_in;
   logic [62:0]      jmag_ff, jmag_in;
   logic [62:0]      cmag_ff, cmag_in;
   logic             cneg_ff, cneg_in;
   logic [62:0]      now_ff, now_in;
   logic [62:0]      dl_ff, dl_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [62:0]      rsp_dl_ff, rsp_dl_in;

   ctrl_word_type    cw;
   logic [31:0]      mul_a, mul_b;
   logic [6:0]       shamt;
   logic [ACC_W-1:0] addend;
   logic             dneg;
   logic [31:0]      dpos, absd;
   logic [62:0]      smag_sat, jmag_sat;
   logic [62:0]      max63, min63;
   logic [62:0]      cl_mag;
   logic             cl_neg;
   logic             jsgn;
   logic [63:0]      sum_same, diff_cj, diff_jc;
   logic [62:0]      comb_mag;
   logic             comb_neg;
   logic [62:0]      floor_t;
   logic [63:0]      dsum;

   assign cw    = ctrl.cw;
   assign max63 = {31'b0, cfg.max_timeout};
   assign min63 = {31'b0, cfg.min_timeout};

   // |2r - 1| in Q1.31 from the generator state
   assign dneg = ~lcg_ff[30];
   assign dpos = {1'b0, lcg_ff[29:0], 1'b0};
   assign absd = dneg ? (32'h8000_0000 - dpos) : dpos;

   // multiplier operands
   always_comb begin
      unique case (cw.a_sel)
         MA_ZERO:    mul_a = '0;
         MA_GROWTH:  mul_a = {8'b0, cfg.growth_factor};
         MA_LCG_MUL: mul_a = {1'b0, LCG_MUL};
         MA_ABSD:    mul_a = absd;
         MA_COEF_LO: mul_a = coef_ff[31:0];
         MA_COEF_HI: mul_a = {15'b0, coef_ff[48:32]};
         default:    mul_a = '0;
      endcase
      unique case (cw.b_sel)
         MB_ZERO:    mul_b = '0;
         MB_TMAG_LO: mul_b = tmag_ff[31:0];
         MB_TMAG_HI: mul_b = {1'b0, tmag_ff[62:32]};
         MB_LCG:     mul_b = {1'b0, lcg_ff};
         MB_JF:      mul_b = {15'b0, cfg.jitter_fraction};
         MB_SMAG_LO: mul_b = smag_ff[31:0];
         MB_SMAG_HI: mul_b = {1'b0, smag_ff[62:32]};
         default:    mul_b = '0;
      endcase
   end

   assign prod_in = {32'b0, mul_a} * {32'b0, mul_b};

   // accumulator
   always_comb begin
      unique case (cw.acc_sh)
         SH_0:    shamt = 7'd0;
         SH_32:   shamt = 7'd32;
         SH_64:   shamt = 7'd64;
         default: shamt = 7'd0;
      endcase
      addend = {{(ACC_W-64){1'b0}}, prod_ff} << shamt;
      unique case (cw.acc_op)
         ACC_HOLD: acc_in = acc_ff;
         ACC_LOAD: acc_in = addend;
         ACC_ADD:  acc_in = acc_ff + addend;
         default:  acc_in = acc_ff;
      endcase
   end

   // saturating extracts of the two scaled products
   assign smag_sat = (|acc_ff[ACC_W-1:SMAG_LSB+63]) ? MAG_MAX : acc_ff[SMAG_LSB+62:SMAG_LSB];
   assign jmag_sat = (|acc_ff[ACC_W-1:JMAG_LSB+63]) ? MAG_MAX : acc_ff[JMAG_LSB+62:JMAG_LSB];

   // clamp against max: a negative scaled value is always below it
   assign cl_neg = tneg_ff && (|smag_ff);
   assign cl_mag = cl_neg ? smag_ff :
                   (tneg_ff ? '0 : ((smag_ff > max63) ? max63 : smag_ff));

   // clamped + jitter, saturated to +-MAG_MAX
   assign jsgn     = (cfneg_ff != tneg_ff) && (|jmag_ff);
   assign sum_same = {1'b0, cmag_ff} + {1'b0, jmag_ff};
   assign diff_cj  = {1'b0, cmag_ff} - {1'b0, jmag_ff};
   assign diff_jc  = {1'b0, jmag_ff} - {1'b0, cmag_ff};

   always_comb begin
      if (cneg_ff == jsgn) begin
         comb_mag = sum_same[63] ? MAG_MAX : sum_same[62:0];
         comb_neg = cneg_ff;
      end else if (diff_cj[63]) begin
         comb_mag = diff_jc[62:0];
         comb_neg = jsgn;
      end else begin
         comb_mag = diff_cj[62:0];
         comb_neg = cneg_ff && (|diff_cj[62:0]);
      end
   end

   // deadline = now + max(timeout, min), saturated
   assign floor_t = tneg_ff ? min63 : ((tmag_ff > min63) ? tmag_ff : min63);
   assign dsum    = {1'b0, now_ff} + {1'b0, floor_t};

   // write-back
   always_comb begin
      tmag_in  = tmag_ff;
      tneg_in  = tneg_ff;
      lcg_in   = lcg_ff;
      smag_in  = smag_ff;
      coef_in  = coef_ff;
      cfneg_in = cfneg_ff;
      jmag_in  = jmag_ff;
      cmag_in  = cmag_ff;
      cneg_in  = cneg_ff;
      dl_in    = dl_ff;
      unique case (cw.wb)
         WB_NONE: ;
         WB_LOAD_INIT: begin
            tmag_in = {31'b0, cfg.initial_timeout};
            tneg_in = 1'b0;
         end
         WB_LCG:   lcg_in = prod_ff[30:0] + LCG_INC;
         WB_SMAG:  smag_in = smag_sat;
         WB_COEF: begin
            coef_in  = prod_ff[48:0];
            cfneg_in = dneg && (|cfg.jitter_fraction);
         end
         WB_JMAG:  jmag_in = jmag_sat;
         WB_CLAMP: begin
            cmag_in = cl_mag;
            cneg_in = cl_neg;
         end
         WB_COMBINE: begin
            tmag_in = comb_mag;
            tneg_in = comb_neg;
         end
         WB_DEADLINE: dl_in = dsum[63] ? MAG_MAX : dsum[62:0];
         default: ;
      endcase
      if (seed_wr.load) lcg_in = seed_wr.value;
   end

   assign now_in = ctrl.accept ? now_ms : now_ff;

   // result register
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_dl_in    = rsp_dl_ff;
      if (ctrl.emit) begin
         rsp_valid_in = 1'b1;
         rsp_dl_in    = dl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tmag_ff      <= '0;
         tneg_ff      <= 1'b0;
         lcg_ff       <= SEED_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         tmag_ff      <= tmag_in;
         tneg_ff      <= tneg_in;
         lcg_ff       <= lcg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      smag_ff   <= smag_in;
      coef_ff   <= coef_in;
      cfneg_ff  <= cfneg_in;
      jmag_ff   <= jmag_in;
      cmag_ff   <= cmag_in;
      cneg_ff   <= cneg_in;
      now_ff    <= now_in;
      dl_ff     <= dl_in;
      rsp_dl_ff <= rsp_dl_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_deadline_ms = rsp_dl_ff;

endmodule

// ===== rtl/exponential_backoff_jitter.sv =====
// ----------------------------------------------------------------------------
// exponential_backoff_jitter
// Retry-deadline generator with exponential growth and LCG jitter.
// ----------------------------------------------------------------------------
//
//   channel | dir | beat contents               | handshake
//   --------+-----+-----------------------------+-----------------------------
//   req_ch  | in  | action[1:0], now_ms[62:0]   | valid && ready
//   rsp_ch  | out | deadline_ms[62:0]           | valid && ready
//   csr_*   | in  | csr_index[2:0], csr_wdata   | csr_we, no wait, no readback
//
// Program: one beat per item, then a microcode run for begin, step, reset or
//   the unused code; step walks seven products and the LCG advance through
//   the single shared 32x32 multiplier.
// Reset: synchronous; timeout 0, generator at the reset seed, no clearing.
// Stalls: a finished deadline waits in the result register; a new request
//   is still taken, and only the emit step waits for that register to free.
//
module exponential_backoff_jitter import ebj_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   ebj_chan_if.sink              req_ch,
   ebj_chan_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type     cfg;
   seed_wr_type seed_wr;
   dp_ctrl_type dp_ctrl;
   logic        req_ready;
   logic        req_accept;
   logic        out_free;
   logic        rsp_valid;
   logic [62:0] rsp_deadline_ms;

   assign req_accept = req_ch.valid && req_ready;
   assign req_ch.ready = req_ready;

   // configuration registers
   ebj_csr u_ebj_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .seed_wr   (seed_wr)
   );

   // microcode sequencer: dispatches on the action, steps the program
   ebj_seq u_ebj_seq (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_accept),
      .action   (req_ch.payload.action),
      .out_free (out_free),
      .ready    (req_ready),
      .ctrl     (dp_ctrl)
   );

   // datapath driven by the control word
   ebj_dp u_ebj_dp (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (dp_ctrl),
      .cfg             (cfg),
      .seed_wr         (seed_wr),
      .now_ms          (req_ch.payload.now_ms),
      .rsp_ready       (rsp_ch.ready),
      .rsp_valid       (rsp_valid),
      .rsp_deadline_ms (rsp_deadline_ms),
      .out_free        (out_free)
   );

   assign rsp_ch.valid               = rsp_valid;
   assign rsp_ch.payload.deadline_ms = rsp_deadline_ms;

endmodule

// ===== rtl/ebj_checker.sv =====
// ----------------------------------------------------------------------------
// ebj_checker
// Port-level checks of the backoff block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ebj_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [62:0] rsp_deadline_ms
);

   // a held result stays offered
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // a held result keeps its value
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_deadline_ms))

   // the sequencer is busy right after taking a beat
   `ASSERT_NEXT(a_req_busy, clock, reset, req_valid && req_ready, !req_ready)

   // a new result only comes out of a running program
   `ASSERT_IMPLIES(a_rsp_from_run, clock, reset, $rose(rsp_valid), !$past(req_ready))

endmodule

bind exponential_backoff_jitter ebj_checker u_ebj_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_deadline_ms (rsp_ch.payload.deadline_ms)
);
